>>> hw/rtl/assert_macros.svh
// assertion helpers, clocked and disabled while reset is held
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> hw/rtl/cmm_pkg.sv
package cmm_pkg;

  localparam int MAX_DIM_DEF = 8;

  localparam int ELEM_BITS  = 16;
  localparam int ALPHA_BITS = 16;
  localparam int ALPHA_FRAC = 14;
  localparam int ACC_BITS   = 40;
  localparam int PROD_BITS  = ACC_BITS + ALPHA_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int RND_SHIFT  = ELEM_BITS - 1 + ALPHA_FRAC;
  localparam int ENTRY_BITS = 2 * ELEM_BITS;

  localparam int OP_BITS   = 2;
  localparam int IDX_BITS  = 3;
  localparam int DIM_BITS  = 4;
  localparam int CONJ_BITS = 2;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [OP_BITS-1:0] OP_LOAD_A  = OP_BITS'(0);
  localparam logic [OP_BITS-1:0] OP_LOAD_B  = OP_BITS'(1);
  localparam logic [OP_BITS-1:0] OP_COMPUTE = OP_BITS'(2);

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS_M     = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS_N     = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_INNER_K    = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONJ_MODE  = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_REAL = CFG_IDX_BITS'(4);
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_IMAG = CFG_IDX_BITS'(5);

  // sign controls for the complex multiplier combine stage, plus last and scale flags
  typedef struct packed {
    logic last;
    logic scale;
    logic sub_ii;
    logic neg_ri;
    logic neg_ir;
  } cmac_ctrl_t;

endpackage

>>> hw/rtl/cmm_in_if.sv
interface cmm_in_if;
  import cmm_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [OP_BITS-1:0]          op;
  logic [IDX_BITS-1:0]         first_index;
  logic [IDX_BITS-1:0]         second_index;
  logic signed [ELEM_BITS-1:0] elem_real;
  logic signed [ELEM_BITS-1:0] elem_imag;

  modport source (
    output valid, op, first_index, second_index, elem_real, elem_imag,
    input  ready
  );

  modport sink (
    input  valid, op, first_index, second_index, elem_real, elem_imag,
    output ready
  );
endinterface

>>> hw/rtl/cmm_out_if.sv
interface cmm_out_if;
  import cmm_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [IDX_BITS-1:0]         out_row;
  logic [IDX_BITS-1:0]         out_col;
  logic signed [ELEM_BITS-1:0] out_real;
  logic signed [ELEM_BITS-1:0] out_imag;
  logic                        saturated;

  modport source (
    output valid, out_row, out_col, out_real, out_imag, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_row, out_col, out_real, out_imag, saturated,
    output ready
  );
endinterface

>>> hw/rtl/cmm_cmac.sv
module cmm_cmac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_v,
  input  cmm_pkg::cmac_ctrl_t                  in_ctrl,
  input  logic signed [cmm_pkg::ACC_BITS-1:0]  x_re,
  input  logic signed [cmm_pkg::ACC_BITS-1:0]  x_im,
  input  logic signed [cmm_pkg::ALPHA_BITS-1:0] y_re,
  input  logic signed [cmm_pkg::ALPHA_BITS-1:0] y_im,
  output logic                                 out_v,
  output cmm_pkg::cmac_ctrl_t                  out_ctrl,
  output logic signed [cmm_pkg::SUM_BITS-1:0]  sum_re,
  output logic signed [cmm_pkg::SUM_BITS-1:0]  sum_im
);
  import cmm_pkg::*;

  logic signed [PROD_BITS-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [PROD_BITS-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                        p_v_r;
  cmac_ctrl_t                  p_ctrl_r;

  logic signed [SUM_BITS-1:0]  e_rr, e_ii, e_ri, e_ir;
  logic signed [SUM_BITS-1:0]  re_nxt, im_nxt;
  logic signed [SUM_BITS-1:0]  re_r, im_r;
  logic                        s_v_r;
  cmac_ctrl_t                  s_ctrl_r;

  // four partial products, one register stage
  assign p_rr = x_re * y_re;
  assign p_ii = x_im * y_im;
  assign p_ri = x_re * y_im;
  assign p_ir = x_im * y_re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= in_v;
    end
    p_ctrl_r <= in_ctrl;
    p_rr_r   <= p_rr;
    p_ii_r   <= p_ii;
    p_ri_r   <= p_ri;
    p_ir_r   <= p_ir;
  end

  assign e_rr = SUM_BITS'(p_rr_r);
  assign e_ii = SUM_BITS'(p_ii_r);
  assign e_ri = SUM_BITS'(p_ri_r);
  assign e_ir = SUM_BITS'(p_ir_r);

  // conjugation folds into the signs of the ii term and the cross terms
  assign re_nxt = e_rr + (p_ctrl_r.sub_ii ? -e_ii : e_ii);
  assign im_nxt = (p_ctrl_r.neg_ri ? -e_ri : e_ri) + (p_ctrl_r.neg_ir ? -e_ir : e_ir);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= p_v_r;
    end
    s_ctrl_r <= p_ctrl_r;
    re_r     <= re_nxt;
    im_r     <= im_nxt;
  end

  assign out_v    = s_v_r;
  assign out_ctrl = s_ctrl_r;
  assign sum_re   = re_r;
  assign sum_im   = im_r;
endmodule

>>> hw/rtl/complex_matrix_multiply_scaled.sv
// complex matrix element engine, C = alpha * op(A) * op(B) with beta zero
// input channel in_ch carries load and compute words; op selects load A,
// load B or compute. a load writes one Q1.15 complex entry into the local
// A or B store. a compute word for (i,j) walks inner_k stored pairs
// (capped at MAX_DIM) through one shared complex multiplier, one pair a
// cycle, then passes the 40-bit sums through the same multiplier once
// more for the Q2.14 alpha scaling, rounds half up and saturates to Q1.15.
// a compute word holds the input until its result is written; each term
// crosses the store read register and the two stage multiplier, and the
// alpha step crosses the multiplier alone. a compute word outside
// rows_m x cols_n is dropped with no result. the result appears on out_ch
// as the input is released, so one result per compute word in range, and
// loads keep flowing while it waits.
// if out_ch stalls, a following compute word runs up to its scaling step
// and waits there until the result register is free.
// reset restores the register defaults (8 x 8 x 8, no conjugation,
// alpha 1.0) and empties the pipeline; the stores are not cleared, and
// an entry must be loaded before a compute word reads it.
// configuration is written through cfg_we/cfg_index/cfg_wdata; the user
// must write it only while idle, the block does not enforce this.
`include "assert_macros.svh"

module complex_matrix_multiply_scaled #(
  parameter int MAX_DIM = cmm_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  cmm_in_if.sink                             in_ch,
  cmm_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [cmm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [cmm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import cmm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);
  localparam logic [DIM_BITS-1:0] DIM_CAP =
    (MAX_DIM < (1 << DIM_BITS)) ? DIM_BITS'(MAX_DIM) : '1;

  localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
    SUM_BITS'(longint'(1) << (RND_SHIFT - 1));
  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    SUM_BITS'((longint'(1) << (ELEM_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO =
    SUM_BITS'(-(longint'(1) << (ELEM_BITS - 1)));
  localparam logic signed [ELEM_BITS-1:0] ELEM_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
  localparam logic signed [ELEM_BITS-1:0] ELEM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_SWAIT = 3'd4;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d);
    return (d > DIM_CAP) ? DIM_CAP : d;
  endfunction

  // configuration registers
  logic [DIM_BITS-1:0]          rows_m_r, cols_n_r, inner_k_r;
  logic [CONJ_BITS-1:0]         conj_mode_r;
  logic signed [ALPHA_BITS-1:0] alpha_re_r, alpha_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m_r    <= DIM_BITS'(8);
      cols_n_r    <= DIM_BITS'(8);
      inner_k_r   <= DIM_BITS'(8);
      conj_mode_r <= '0;
      alpha_re_r  <= ALPHA_BITS'(16384);
      alpha_im_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_M:     rows_m_r    <= cfg_wdata[DIM_BITS-1:0];
        CFG_COLS_N:     cols_n_r    <= cfg_wdata[DIM_BITS-1:0];
        CFG_INNER_K:    inner_k_r   <= cfg_wdata[DIM_BITS-1:0];
        CFG_CONJ_MODE:  conj_mode_r <= cfg_wdata[CONJ_BITS-1:0];
        CFG_ALPHA_REAL: alpha_re_r  <= ALPHA_BITS'(cfg_wdata);
        CFG_ALPHA_IMAG: alpha_im_r  <= ALPHA_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [2:0]                 state_r, state_nxt;
  logic [IDX_BITS-1:0]        i_r, i_nxt, j_r, j_nxt;
  logic [DIM_BITS-1:0]        l_r, l_nxt, kk_r, kk_nxt;
  logic signed [ACC_BITS-1:0] acc_re_r, acc_re_nxt, acc_im_r, acc_im_nxt;
  logic                       rd_v_r, rd_last_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [IDX_BITS-1:0]        row_r, col_r;
  logic signed [ELEM_BITS-1:0] res_re_r, res_im_r;
  logic                       sat_r;

  logic                 in_ready, in_fire, out_fire;
  logic                 load_ok, cmp_ok, we_a, we_b;
  logic [DIM_BITS-1:0]  rows_cl, cols_cl, kk_cl;
  logic [AW-1:0]        wr_addr, a_addr, b_addr;
  logic                 issue, issue_last, scale_go, res_wr;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_ch.valid && in_ready;
  assign out_fire = out_valid_r && out_ch.ready;

  assign rows_cl = clamp_dim(rows_m_r);
  assign cols_cl = clamp_dim(cols_n_r);
  assign kk_cl   = clamp_dim(inner_k_r);

  assign load_ok = (int'(in_ch.first_index) < MAX_DIM) && (int'(in_ch.second_index) < MAX_DIM);
  assign we_a    = in_fire && (in_ch.op == OP_LOAD_A) && load_ok;
  assign we_b    = in_fire && (in_ch.op == OP_LOAD_B) && load_ok;
  assign cmp_ok  = in_fire && (in_ch.op == OP_COMPUTE)
                && ({1'b0, in_ch.first_index} < rows_cl)
                && ({1'b0, in_ch.second_index} < cols_cl);

  assign wr_addr = AW'(in_ch.first_index) * DIM_A + AW'(in_ch.second_index);
  assign a_addr  = AW'(i_r) * DIM_A + AW'(l_r);
  assign b_addr  = AW'(l_r) * DIM_A + AW'(j_r);

  assign issue      = (state_r == S_RUN);
  assign issue_last = (l_r == kk_r - DIM_BITS'(1));
  assign scale_go   = (state_r == S_SCALE) && (!out_valid_r || out_ch.ready);

  // element stores, one write and one registered read each
  logic [ENTRY_BITS-1:0] a_mem [DEPTH];
  logic [ENTRY_BITS-1:0] b_mem [DEPTH];
  logic [ENTRY_BITS-1:0] rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (we_a) begin
      a_mem[wr_addr] <= {in_ch.elem_real, in_ch.elem_imag};
    end
    rd_a_r <= a_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      b_mem[wr_addr] <= {in_ch.elem_real, in_ch.elem_imag};
    end
    rd_b_r <= b_mem[b_addr];
  end

  // shared complex multiplier: stored pairs first, then acc times alpha
  logic                        cm_in_v, cm_out_v;
  cmac_ctrl_t                  cm_in_ctrl, cm_out_ctrl;
  logic signed [ACC_BITS-1:0]  cm_x_re, cm_x_im;
  logic signed [ALPHA_BITS-1:0] cm_y_re, cm_y_im;
  logic signed [SUM_BITS-1:0]  cm_sum_re, cm_sum_im;
  logic signed [ELEM_BITS-1:0] a_re, a_im, b_re, b_im;

  assign a_re = rd_a_r[ENTRY_BITS-1:ELEM_BITS];
  assign a_im = rd_a_r[ELEM_BITS-1:0];
  assign b_re = rd_b_r[ENTRY_BITS-1:ELEM_BITS];
  assign b_im = rd_b_r[ELEM_BITS-1:0];

  always_comb begin
    cm_in_v = rd_v_r || scale_go;
    if (scale_go) begin
      cm_x_re    = acc_re_r;
      cm_x_im    = acc_im_r;
      cm_y_re    = alpha_re_r;
      cm_y_im    = alpha_im_r;
      cm_in_ctrl = '{last: 1'b0, scale: 1'b1, sub_ii: 1'b1, neg_ri: 1'b0, neg_ir: 1'b0};
    end else begin
      cm_x_re    = ACC_BITS'(a_re);
      cm_x_im    = ACC_BITS'(a_im);
      cm_y_re    = ALPHA_BITS'(b_re);
      cm_y_im    = ALPHA_BITS'(b_im);
      cm_in_ctrl = '{last:   rd_last_r,
                     scale:  1'b0,
                     sub_ii: (conj_mode_r[1] == conj_mode_r[0]),
                     neg_ri: conj_mode_r[0],
                     neg_ir: conj_mode_r[1]};
    end
  end

  cmm_cmac u_cmac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (cm_in_v),
    .in_ctrl  (cm_in_ctrl),
    .x_re     (cm_x_re),
    .x_im     (cm_x_im),
    .y_re     (cm_y_re),
    .y_im     (cm_y_im),
    .out_v    (cm_out_v),
    .out_ctrl (cm_out_ctrl),
    .sum_re   (cm_sum_re),
    .sum_im   (cm_sum_im)
  );

  // round half up, floor shift, saturate
  logic signed [SUM_BITS-1:0]  q_re, q_im;
  logic                        hi_re, lo_re, hi_im, lo_im;
  logic signed [ELEM_BITS-1:0] sat_re, sat_im;

  assign q_re  = (cm_sum_re + ROUND_HALF) >>> RND_SHIFT;
  assign q_im  = (cm_sum_im + ROUND_HALF) >>> RND_SHIFT;
  assign hi_re = (q_re > SAT_HI);
  assign lo_re = (q_re < SAT_LO);
  assign hi_im = (q_im > SAT_HI);
  assign lo_im = (q_im < SAT_LO);
  assign sat_re = hi_re ? ELEM_MAX : (lo_re ? ELEM_MIN : ELEM_BITS'(q_re));
  assign sat_im = hi_im ? ELEM_MAX : (lo_im ? ELEM_MIN : ELEM_BITS'(q_im));

  assign res_wr = cm_out_v && cm_out_ctrl.scale;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    l_nxt         = l_r;
    kk_nxt        = kk_r;
    acc_re_nxt    = acc_re_r;
    acc_im_nxt    = acc_im_r;
    out_valid_nxt = out_valid_r && !out_fire;

    if (cm_out_v && !cm_out_ctrl.scale) begin
      acc_re_nxt = acc_re_r + ACC_BITS'(cm_sum_re);
      acc_im_nxt = acc_im_r + ACC_BITS'(cm_sum_im);
    end

    unique case (state_r)
      S_IDLE: begin
        if (cmp_ok) begin
          i_nxt      = in_ch.first_index;
          j_nxt      = in_ch.second_index;
          l_nxt      = '0;
          kk_nxt     = kk_cl;
          acc_re_nxt = '0;
          acc_im_nxt = '0;
          state_nxt  = (kk_cl == '0) ? S_SCALE : S_RUN;
        end
      end
      S_RUN: begin
        l_nxt = l_r + DIM_BITS'(1);
        if (issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cm_out_v && cm_out_ctrl.last) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (scale_go) begin
          state_nxt = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (res_wr) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= issue;
      out_valid_r <= out_valid_nxt;
    end
    rd_last_r <= issue_last;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    l_r       <= l_nxt;
    kk_r      <= kk_nxt;
    acc_re_r  <= acc_re_nxt;
    acc_im_r  <= acc_im_nxt;
    if (res_wr) begin
      row_r    <= i_r;
      col_r    <= j_r;
      res_re_r <= sat_re;
      res_im_r <= sat_im;
      sat_r    <= hi_re || lo_re || hi_im || lo_im;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = row_r;
  assign out_ch.out_col   = col_r;
  assign out_ch.out_real  = res_re_r;
  assign out_ch.out_imag  = res_im_r;
  assign out_ch.saturated = sat_r;

  `ASSERT_CLK(a_scale_in_swait, clk, rst_n, (cm_out_v && cm_out_ctrl.scale) |-> (state_r == S_SWAIT), "scaled word outside scale wait")
  `ASSERT_CLK(a_mac_in_run, clk, rst_n, (cm_out_v && !cm_out_ctrl.scale) |-> (state_r == S_RUN || state_r == S_DRAIN), "term word after accumulation ended")
  `ASSERT_NEVER(a_no_overwrite, clk, rst_n, res_wr && out_valid_r, "result register overwritten")
  `ASSERT_CLK(a_term_in_range, clk, rst_n, (state_r == S_RUN) |-> (l_r < kk_r), "inner index past term count")
endmodule

>>> tb/sv/cmm_tb_pkg.sv
package cmm_tb_pkg;
  import cmm_pkg::*;

  localparam int ENTRIES = MAX_DIM_DEF * MAX_DIM_DEF;

  // op code the block does not use, sent as noise
  localparam logic [OP_BITS-1:0] OP_UNUSED = OP_BITS'(3);

  typedef struct packed {
    logic [OP_BITS-1:0]          op;
    logic [IDX_BITS-1:0]         first_index;
    logic [IDX_BITS-1:0]         second_index;
    logic signed [ELEM_BITS-1:0] elem_real;
    logic signed [ELEM_BITS-1:0] elem_imag;
  } cmm_word_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]         row;
    logic [IDX_BITS-1:0]         col;
    logic signed [ELEM_BITS-1:0] re;
    logic signed [ELEM_BITS-1:0] im;
    logic                        sat;
  } cmm_elem_t;

  function automatic int clamp_dim(logic [DIM_BITS-1:0] d);
    return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
  endfunction

  class cmm_scoreboard;
    logic signed [ELEM_BITS-1:0]  a_re[ENTRIES];
    logic signed [ELEM_BITS-1:0]  a_im[ENTRIES];
    logic signed [ELEM_BITS-1:0]  b_re[ENTRIES];
    logic signed [ELEM_BITS-1:0]  b_im[ENTRIES];
    logic [DIM_BITS-1:0]          rows_m;
    logic [DIM_BITS-1:0]          cols_n;
    logic [DIM_BITS-1:0]          inner_k;
    logic [CONJ_BITS-1:0]         conj_mode;
    logic signed [ALPHA_BITS-1:0] alpha_re;
    logic signed [ALPHA_BITS-1:0] alpha_im;
    cmm_elem_t                    pending_elems[$];
    int                           mismatches;

    function new();
      foreach (a_re[e]) begin
        a_re[e] = '0;
        a_im[e] = '0;
        b_re[e] = '0;
        b_im[e] = '0;
      end
      rows_m     = DIM_BITS'(8);
      cols_n     = DIM_BITS'(8);
      inner_k    = DIM_BITS'(8);
      conj_mode  = '0;
      alpha_re   = ALPHA_BITS'(16384);
      alpha_im   = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_ROWS_M:     rows_m    = data[DIM_BITS-1:0];
        CFG_COLS_N:     cols_n    = data[DIM_BITS-1:0];
        CFG_INNER_K:    inner_k   = data[DIM_BITS-1:0];
        CFG_CONJ_MODE:  conj_mode = data[CONJ_BITS-1:0];
        CFG_ALPHA_REAL: alpha_re  = data;
        CFG_ALPHA_IMAG: alpha_im  = data;
        default: ;
      endcase
    endfunction

    function logic signed [ELEM_BITS-1:0] clip_elem(longint v, inout bit hit);
      if (v > 32767) begin
        hit = 1'b1;
        return 16'sh7fff;
      end
      if (v < -32768) begin
        hit = 1'b1;
        return 16'sh8000;
      end
      return ELEM_BITS'(v);
    endfunction

    function cmm_elem_t product_elem(int i, int j);
      logic signed [ACC_BITS-1:0] acc_re;
      logic signed [ACC_BITS-1:0] acc_im;
      longint ar, ai, br, bi, yr, yi, half;
      bit hit;
      int nk;
      cmm_elem_t r;
      nk = clamp_dim(inner_k);
      acc_re = '0;
      acc_im = '0;
      for (int l = 0; l < nk; l++) begin
        ar = a_re[i * MAX_DIM_DEF + l];
        ai = a_im[i * MAX_DIM_DEF + l];
        br = b_re[l * MAX_DIM_DEF + j];
        bi = b_im[l * MAX_DIM_DEF + j];
        if (conj_mode[1]) ai = -ai;
        if (conj_mode[0]) bi = -bi;
        // 40-bit sums wrap like the hardware accumulator
        acc_re = acc_re + ACC_BITS'(ar * br - ai * bi);
        acc_im = acc_im + ACC_BITS'(ar * bi + ai * br);
      end
      yr = longint'(alpha_re) * longint'(acc_re) - longint'(alpha_im) * longint'(acc_im);
      yi = longint'(alpha_re) * longint'(acc_im) + longint'(alpha_im) * longint'(acc_re);
      half = longint'(1) <<< (RND_SHIFT - 1);
      hit = 1'b0;
      r.row = IDX_BITS'(i);
      r.col = IDX_BITS'(j);
      r.re  = clip_elem((yr + half) >>> RND_SHIFT, hit);
      r.im  = clip_elem((yi + half) >>> RND_SHIFT, hit);
      r.sat = hit;
      return r;
    endfunction

    function void note_word(cmm_word_t w);
      int idx;
      idx = int'(w.first_index) * MAX_DIM_DEF + int'(w.second_index);
      case (w.op)
        OP_LOAD_A: begin
          a_re[idx] = w.elem_real;
          a_im[idx] = w.elem_imag;
        end
        OP_LOAD_B: begin
          b_re[idx] = w.elem_real;
          b_im[idx] = w.elem_imag;
        end
        OP_COMPUTE: begin
          if (w.first_index < clamp_dim(rows_m) && w.second_index < clamp_dim(cols_n))
            pending_elems.push_back(product_elem(w.first_index, w.second_index));
        end
        default: ;
      endcase
    endfunction

    function void check_elem(cmm_elem_t got);
      cmm_elem_t want;
      if (pending_elems.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: row %0d col %0d re %0d im %0d sat %0b",
                   got.row, got.col, got.re, got.im, got.sat);
        mismatches++;
        return;
      end
      want = pending_elems.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.re !== want.re ||
          got.im !== want.im || got.sat !== want.sat) begin
        if (mismatches < 10)
          $display("mismatch: expected row %0d col %0d re %0d im %0d sat %0b, got row %0d col %0d re %0d im %0d sat %0b",
                   want.row, want.col, want.re, want.im, want.sat,
                   got.row, got.col, got.re, got.im, got.sat);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_elems.size();
    endfunction
  endclass

endpackage

>>> tb/sv/tb_complex_matrix_multiply_scaled.sv
module tb_complex_matrix_multiply_scaled;
  timeunit 1ns;
  timeprecision 1ps;

  import cmm_pkg::*;
  import cmm_tb_pkg::*;

  localparam int  SETTLE_CYCLES = 24;
  localparam int  LONG_HOLD     = 400;
  localparam int  PHASE_WORDS   = 75;
  localparam int  RANDOM_PHASES = 8;
  localparam longint CYCLE_LIMIT = 300000;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  cmm_in_if  in_ch();
  cmm_out_if out_ch();

  complex_matrix_multiply_scaled DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  cmm_scoreboard sb;
  int     send_pct   = 0;
  int     stall_pct  = 0;
  int     hold_req   = 0;
  int     hold_taken = 0;
  int     hold_left  = 0;
  longint cycles     = 0;
  bit     a_written[ENTRIES];
  bit     b_written[ENTRIES];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check taken words, then decide ready for the next edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_elem(cmm_elem_t'{out_ch.out_row, out_ch.out_col, out_ch.out_real,
                                  out_ch.out_imag, out_ch.saturated});
      if (hold_req != hold_taken) begin
        hold_taken = hold_req;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic cmm_word_t mk_word(logic [OP_BITS-1:0] op, logic [IDX_BITS-1:0] f,
                                        logic [IDX_BITS-1:0] s, logic [ELEM_BITS-1:0] re,
                                        logic [ELEM_BITS-1:0] im);
    cmm_word_t w;
    w.op           = op;
    w.first_index  = f;
    w.second_index = s;
    w.elem_real    = re;
    w.elem_imag    = im;
    return w;
  endfunction

  function automatic logic [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return ELEM_BITS'($urandom);
    endcase
  endfunction

  function automatic int rand_dim();
    case ($urandom_range(15))
      0:       return 0;
      1:       return $urandom_range(15, 9);
      default: return $urandom_range(8, 1);
    endcase
  endfunction

  function automatic logic [ALPHA_BITS-1:0] rand_alpha();
    case ($urandom_range(5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return ALPHA_BITS'($urandom);
    endcase
  endfunction

  // mostly compute words whose operands are all loaded; a compute whose
  // operands are missing turns into a load of the first missing entry
  function automatic void pick_word(output cmm_word_t w, output bit counts);
    int r, nr, nc, nk, i, j;
    w = mk_word(OP_LOAD_A, IDX_BITS'($urandom), IDX_BITS'($urandom), rand_elem(),
                rand_elem());
    counts = 1'b1;
    nr = clamp_dim(sb.rows_m);
    nc = clamp_dim(sb.cols_n);
    nk = clamp_dim(sb.inner_k);
    r  = $urandom_range(99);
    if (r < 8 || (r >= 50 && (nr == 0 || nc == 0))) begin
      counts = 1'b0;
      if (r < 4 || (nr == MAX_DIM_DEF && nc == MAX_DIM_DEF)) begin
        w.op = OP_UNUSED;
      end else begin
        w.op = OP_COMPUTE;
        if (nc == MAX_DIM_DEF || (nr < MAX_DIM_DEF && $urandom_range(1)))
          w.first_index = IDX_BITS'($urandom_range(MAX_DIM_DEF - 1, nr));
        else
          w.second_index = IDX_BITS'($urandom_range(MAX_DIM_DEF - 1, nc));
      end
    end else if (r < 50) begin
      w.op = (r % 2) ? OP_LOAD_B : OP_LOAD_A;
    end else begin
      i = $urandom_range(nr - 1, 0);
      j = $urandom_range(nc - 1, 0);
      for (int l = 0; l < nk; l++) begin
        if (!a_written[i * MAX_DIM_DEF + l]) begin
          w.first_index  = IDX_BITS'(i);
          w.second_index = IDX_BITS'(l);
          return;
        end
        if (!b_written[l * MAX_DIM_DEF + j]) begin
          w.op           = OP_LOAD_B;
          w.first_index  = IDX_BITS'(l);
          w.second_index = IDX_BITS'(j);
          return;
        end
      end
      w.op           = OP_COMPUTE;
      w.first_index  = IDX_BITS'(i);
      w.second_index = IDX_BITS'(j);
    end
  endfunction

  task automatic send_word(input cmm_word_t w);
    int idx;
    idx = int'(w.first_index) * MAX_DIM_DEF + int'(w.second_index);
    in_ch.valid        <= 1'b1;
    in_ch.op           <= w.op;
    in_ch.first_index  <= w.first_index;
    in_ch.second_index <= w.second_index;
    in_ch.elem_real    <= w.elem_real;
    in_ch.elem_imag    <= w.elem_imag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(w);
    if (w.op == OP_LOAD_A) a_written[idx] = 1'b1;
    if (w.op == OP_LOAD_B) b_written[idx] = 1'b1;
  endtask

  task automatic put(input logic [OP_BITS-1:0] op, input int f, input int s,
                     input logic [ELEM_BITS-1:0] re, input logic [ELEM_BITS-1:0] im);
    send_word(mk_word(op, IDX_BITS'(f), IDX_BITS'(s), re, im));
  endtask

  task automatic sender_gap();
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() > 0);
  endtask

  // a word may still be in flight after the last result, so settle too
  task automatic drain();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input int rows, input int cols, input int k, input int conj,
                              input logic [ALPHA_BITS-1:0] are,
                              input logic [ALPHA_BITS-1:0] aim);
    logic [CFG_IDX_BITS-1:0]  regs[6];
    logic [CFG_DATA_BITS-1:0] vals[6];
    regs = '{CFG_ROWS_M, CFG_COLS_N, CFG_INNER_K, CFG_CONJ_MODE, CFG_ALPHA_REAL,
             CFG_ALPHA_IMAG};
    vals = '{CFG_DATA_BITS'(rows), CFG_DATA_BITS'(cols), CFG_DATA_BITS'(k),
             CFG_DATA_BITS'(conj), are, aim};
    for (int r = 0; r < 6; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[r];
      cfg_wdata <= vals[r];
      @(posedge clk);
      sb.set_reg(regs[r], vals[r]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_pct = 0;  stall_pct = 0;  end
      1: begin send_pct = 47; stall_pct = 0;  end
      2: begin send_pct = 0;  stall_pct = 47; end
      default: begin send_pct = 27; stall_pct = 27; end
    endcase
  endtask

  task automatic run_random(input int target, input bit pressure);
    cmm_word_t w;
    bit counts;
    bit paused;
    int counted;
    counted = 0;
    paused  = 1'b0;
    // long receiver hold while words keep coming, so the input backs up
    if (pressure) hold_req++;
    while (counted < target) begin
      pick_word(w, counts);
      sender_gap();
      send_word(w);
      if (counts) counted++;
      if (pressure && !paused && counted >= target / 2) begin
        paused = 1'b1;
        wait_results();
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_LOAD_A;
    in_ch.first_index  = '0;
    in_ch.second_index = '0;
    in_ch.elem_real    = '0;
    in_ch.elem_imag    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of the elements, single inner term
    set_idling(0);
    write_config(8, 8, 1, 0, 16'sd16384, 16'sd0);
    put(OP_LOAD_A, 0, 0, 16'h7fff, 16'h8000);
    put(OP_LOAD_B, 0, 0, 16'h7fff, 16'h7fff);
    put(OP_LOAD_A, 7, 0, 16'h8000, 16'h8000);
    put(OP_LOAD_B, 0, 7, 16'h8000, 16'h7fff);
    put(OP_COMPUTE, 0, 0, 16'h0000, 16'hffff);
    put(OP_COMPUTE, 0, 7, 16'hffff, 16'h0000);
    put(OP_COMPUTE, 7, 0, 16'h0000, 16'h0000);
    put(OP_COMPUTE, 7, 7, 16'hffff, 16'hffff);
    put(OP_UNUSED, 7, 7, 16'hffff, 16'hffff);
    put(OP_COMPUTE, 7, 7, 16'h0000, 16'h0000);
    drain();

    // zero inner terms, dimensions above the store size
    write_config(15, 15, 0, 3, 16'h8000, 16'h8000);
    put(OP_COMPUTE, 7, 7, 16'h0000, 16'h0000);
    put(OP_COMPUTE, 0, 3, 16'h0000, 16'h0000);
    drain();

    // 1x1 result area: everything outside is dropped
    write_config(1, 1, 1, 3, 16'h8000, 16'h7fff);
    put(OP_COMPUTE, 0, 0, 16'h0000, 16'h0000);
    put(OP_COMPUTE, 0, 7, 16'h0000, 16'h0000);
    put(OP_COMPUTE, 7, 0, 16'h0000, 16'h0000);
    put(OP_UNUSED, 0, 0, 16'h0000, 16'h0000);
    drain();

    write_config(8, 8, 1, 1, 16'h7fff, 16'h8000);
    put(OP_COMPUTE, 7, 7, 16'h0000, 16'h0000);
    put(OP_COMPUTE, 0, 7, 16'h0000, 16'h0000);
    drain();

    write_config(8, 8, 1, 2, -16'sd16384, 16'sd16384);
    put(OP_COMPUTE, 7, 0, 16'h0000, 16'h0000);
    put(OP_LOAD_A, 0, 0, 16'h0001, 16'hffff);
    put(OP_COMPUTE, 0, 0, 16'h0000, 16'h0000);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idling(p % 4);
      if (p == 0)
        write_config(8, 8, 8, 0, 16'h7fff, 16'h7fff);
      else if (p == 1)
        write_config(1, 1, 1, 2, 16'h8000, 16'h8000);
      else if (p == 4)
        write_config(4, 4, 2, 1, rand_alpha(), rand_alpha());
      else
        write_config(rand_dim(), rand_dim(), rand_dim(), $urandom_range(3), rand_alpha(),
                     rand_alpha());
      run_random(PHASE_WORDS, p == 4);
      drain();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
